// ===== hdl/shht_pkg.sv =====
// Shared types, widths and codes for the segment hover hit test.
package shht_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;

  // Internal datapath widths
  localparam int EXT_W   = 18;  // doubled coordinate plus box size
  localparam int CTR_W   = 20;  // centre offset at scale 4
  localparam int DIFF_W  = 19;  // segment and pointer vectors at scale 2
  localparam int MUL_W   = 20;  // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 76;  // holds the widest exact compare
  localparam int LEN_W   = 36;  // squared length and cross magnitude
  localparam int DOT_W   = 37;
  localparam int R_W     = 17;  // hit radius at scale 2
  localparam int RSQ_W   = 33;
  localparam int PIECE_W = 18;  // limb size for the wide product

  localparam int RADIUS_PAD  = 80;  // 5 pixels in Q12.4
  localparam int QUEUE_DEPTH = 2;

  // Configuration
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_SIZE = 1'd1;
  localparam logic [SIZE_W-1:0] LINE_WIDTH_RST  = 15'd32;
  localparam logic [SIZE_W-1:0] CENTRE_SIZE_RST = 15'd256;

  // Hover event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  typedef enum logic [1:0] {
    KIND_BLOCKED = 2'd0,
    KIND_MISS    = 2'd1,
    KIND_TEST    = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic        [SIZE_W-1:0]  from_w;
    logic        [SIZE_W-1:0]  from_h;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic        [SIZE_W-1:0]  to_w;
    logic        [SIZE_W-1:0]  to_h;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      blocked;
    logic                      ends_present;
  } item_t;

  typedef struct packed {
    logic       hover;
    logic       centre_hover;
    logic [1:0] hover_event;
  } result_t;

  // Classified move as it waits between front and back
  typedef struct packed {
    kind_t                    kind;
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [DIFF_W-1:0] wx;
    logic signed [DIFF_W-1:0] wy;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ===== hdl/shht_front.sv =====
// Front end: takes pointer moves and turns them into classified work beats.
module shht_front (
  input  logic                  item_valid,
  output logic                  item_ready,
  input  shht_pkg::item_t       item,
  input  shht_pkg::queue_stat_t stat,
  output logic                  push,
  output shht_pkg::work_t       work
);

  localparam int EXT_PAD = shht_pkg::EXT_W - shht_pkg::COORD_W - 1;

  // Box centre at scale 2: twice the corner plus the size
  function automatic logic signed [shht_pkg::EXT_W-1:0] end_centre(
    input logic signed [shht_pkg::COORD_W-1:0] pos,
    input logic        [shht_pkg::SIZE_W-1:0]  size
  );
    logic signed [shht_pkg::EXT_W-1:0] twice;
    twice = {{EXT_PAD{pos[shht_pkg::COORD_W-1]}}, pos, 1'b0};
    return twice + $signed(shht_pkg::EXT_W'(size));
  endfunction

  logic signed [shht_pkg::EXT_W-1:0] fx, fy, tx, ty, px, py;

  assign fx = end_centre(item.from_x, item.from_w);
  assign fy = end_centre(item.from_y, item.from_h);
  assign tx = end_centre(item.to_x, item.to_w);
  assign ty = end_centre(item.to_y, item.to_h);
  assign px = {{EXT_PAD{item.point_x[shht_pkg::COORD_W-1]}}, item.point_x, 1'b0};
  assign py = {{EXT_PAD{item.point_y[shht_pkg::COORD_W-1]}}, item.point_y, 1'b0};

  // Handshake: take a beat whenever the queue has room
  assign item_ready = !stat.full;
  assign push       = item_valid && item_ready;

  // Classify and form the vectors the back end multiplies
  always_comb begin
    if (item.blocked) begin
      work.kind = shht_pkg::KIND_BLOCKED;
    end else if (!item.ends_present) begin
      work.kind = shht_pkg::KIND_MISS;
    end else begin
      work.kind = shht_pkg::KIND_TEST;
    end
    work.cx = (shht_pkg::CTR_W'(px) <<< 1) - (shht_pkg::CTR_W'(fx) + shht_pkg::CTR_W'(tx));
    work.cy = (shht_pkg::CTR_W'(py) <<< 1) - (shht_pkg::CTR_W'(fy) + shht_pkg::CTR_W'(ty));
    work.ax = shht_pkg::DIFF_W'(tx) - shht_pkg::DIFF_W'(fx);
    work.ay = shht_pkg::DIFF_W'(ty) - shht_pkg::DIFF_W'(fy);
    work.vx = shht_pkg::DIFF_W'(px) - shht_pkg::DIFF_W'(fx);
    work.vy = shht_pkg::DIFF_W'(py) - shht_pkg::DIFF_W'(fy);
    work.wx = shht_pkg::DIFF_W'(px) - shht_pkg::DIFF_W'(tx);
    work.wy = shht_pkg::DIFF_W'(py) - shht_pkg::DIFF_W'(ty);
  end

endmodule

// ===== hdl/shht_fifo.sv =====
// Short work queue between the front and back ends.
module shht_fifo #(
  parameter int DEPTH = shht_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  shht_pkg::work_t       wdata,
  input  logic                  pop,
  output shht_pkg::work_t       rdata,
  output shht_pkg::queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  shht_pkg::work_t    entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   level;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign rdata      = entries[rd_ptr];
  assign stat.empty = (level == '0);
  assign stat.full  = (level == CNT_W'(DEPTH));

endmodule

// ===== hdl/shht_back.sv =====
// Back end: multiply sequencer for the hit tests, hover flags and result register.
module shht_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [shht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shht_pkg::SIZE_W-1:0]         cfg_data,
  input  shht_pkg::work_t                     head,
  input  shht_pkg::queue_stat_t               stat,
  output logic                                pop,
  output logic                                result_valid,
  input  logic                                result_ready,
  output shht_pkg::result_t                   result
);

  localparam int ACC_W   = shht_pkg::ACC_W;
  localparam int MUL_W   = shht_pkg::MUL_W;
  localparam int LEN_W   = shht_pkg::LEN_W;
  localparam int RSQ_W   = shht_pkg::RSQ_W;
  localparam int PIECE_W = shht_pkg::PIECE_W;

  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_QUAD = 6'd2;
  localparam logic [5:0] SH_MID  = 6'(PIECE_W);
  localparam logic [5:0] SH_MID2 = 6'(PIECE_W + 1);
  localparam logic [5:0] SH_HI   = 6'(2 * PIECE_W);

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001,
    ST_CXX  = 22'h000002,
    ST_CYY  = 22'h000004,
    ST_CSS  = 22'h000008,
    ST_LAA  = 22'h000010,
    ST_LBB  = 22'h000020,
    ST_DAV  = 22'h000040,
    ST_DBV  = 22'h000080,
    ST_RSQ  = 22'h000100,
    ST_BR   = 22'h000200,
    ST_E2   = 22'h000400,
    ST_ECMP = 22'h000800,
    ST_X2   = 22'h001000,
    ST_W0   = 22'h002000,
    ST_W1   = 22'h004000,
    ST_W2   = 22'h008000,
    ST_W3   = 22'h010000,
    ST_W4   = 22'h020000,
    ST_W5   = 22'h040000,
    ST_W6   = 22'h080000,
    ST_WCMP = 22'h100000,
    ST_FIN  = 22'h200000
  } state_t;

  // Zero-extend an unsigned limb into a multiplier operand
  function automatic logic signed [MUL_W-1:0] limb(input logic [PIECE_W-1:0] v);
    return $signed(MUL_W'(v));
  endfunction

  state_t state, state_next;

  logic [shht_pkg::SIZE_W-1:0]       line_width;
  logic [shht_pkg::SIZE_W-1:0]       centre_size;
  logic [shht_pkg::R_W-1:0]          radius;

  logic signed [ACC_W-1:0]           acc, acc_next, acc_abs, term;
  logic signed [MUL_W-1:0]           mul_a, mul_b;
  logic signed [shht_pkg::PROD_W-1:0] prod;
  logic [5:0]                        mul_sh;
  logic                              acc_en, acc_clr, acc_neg;

  logic [LEN_W-1:0]                  len2, cr;
  logic signed [shht_pkg::DOT_W-1:0] dot;
  logic [RSQ_W-1:0]                  r2;
  logic                              hc, hl, sel_w;
  logic                              hover_flag, centre_hover_flag;
  logic                              acc_le0, dot_le0, dot_ge_len;
  logic                              hover_next, centre_next;
  logic [1:0]                        event_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= shht_pkg::LINE_WIDTH_RST;
      centre_size <= shht_pkg::CENTRE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shht_pkg::REG_LINE_WIDTH:  line_width  <= cfg_data;
        shht_pkg::REG_CENTRE_SIZE: centre_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hit radius at scale 2
  assign radius = {(shht_pkg::R_W - 1)'(line_width) + (shht_pkg::R_W - 1)'(shht_pkg::RADIUS_PAD),
                   1'b0};

  // Shared multiplier and accumulator
  assign prod     = mul_a * mul_b;
  assign term     = ACC_W'(prod) <<< mul_sh;
  assign acc_next = (acc_clr ? '0 : acc) + (acc_neg ? -term : term);
  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;
  assign acc_le0  = acc[ACC_W-1] || (acc == '0);

  assign dot_le0    = dot[shht_pkg::DOT_W-1] || (dot == '0);
  assign dot_ge_len = !dot[shht_pkg::DOT_W-1] && (dot[LEN_W-1:0] >= len2);

  // Sequencer: at most one product per step
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    mul_sh     = SH_NONE;
    acc_en     = 1'b0;
    acc_clr    = 1'b0;
    acc_neg    = 1'b0;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!stat.empty) begin
          state_next = (head.kind == shht_pkg::KIND_TEST) ? ST_CXX : ST_FIN;
        end
      end
      ST_CXX: begin
        mul_a = MUL_W'(head.cx); mul_b = MUL_W'(head.cx);
        acc_en = 1'b1; acc_clr = 1'b1;
        state_next = ST_CYY;
      end
      ST_CYY: begin
        mul_a = MUL_W'(head.cy); mul_b = MUL_W'(head.cy);
        acc_en = 1'b1;
        state_next = ST_CSS;
      end
      ST_CSS: begin
        mul_a = $signed(MUL_W'(centre_size)); mul_b = $signed(MUL_W'(centre_size));
        mul_sh = SH_QUAD; acc_en = 1'b1; acc_neg = 1'b1;
        state_next = ST_LAA;
      end
      ST_LAA: begin
        if (acc_le0) begin
          state_next = ST_FIN;
        end else begin
          mul_a = MUL_W'(head.ax); mul_b = MUL_W'(head.ax);
          acc_en = 1'b1; acc_clr = 1'b1;
          state_next = ST_LBB;
        end
      end
      ST_LBB: begin
        mul_a = MUL_W'(head.ay); mul_b = MUL_W'(head.ay);
        acc_en = 1'b1;
        state_next = ST_DAV;
      end
      ST_DAV: begin
        if (acc == '0) begin
          state_next = ST_FIN;
        end else begin
          mul_a = MUL_W'(head.ax); mul_b = MUL_W'(head.vx);
          acc_en = 1'b1; acc_clr = 1'b1;
          state_next = ST_DBV;
        end
      end
      ST_DBV: begin
        mul_a = MUL_W'(head.ay); mul_b = MUL_W'(head.vy);
        acc_en = 1'b1;
        state_next = ST_RSQ;
      end
      ST_RSQ: begin
        mul_a = $signed(MUL_W'(radius)); mul_b = $signed(MUL_W'(radius));
        acc_en = 1'b1; acc_clr = 1'b1;
        state_next = ST_BR;
      end
      ST_BR: begin
        acc_en = 1'b1; acc_clr = 1'b1;
        if (dot_le0) begin
          mul_a = MUL_W'(head.vx); mul_b = MUL_W'(head.vx);
          state_next = ST_E2;
        end else if (dot_ge_len) begin
          mul_a = MUL_W'(head.wx); mul_b = MUL_W'(head.wx);
          state_next = ST_E2;
        end else begin
          mul_a = MUL_W'(head.ax); mul_b = MUL_W'(head.vy);
          state_next = ST_X2;
        end
      end
      ST_E2: begin
        mul_a = sel_w ? MUL_W'(head.wy) : MUL_W'(head.vy);
        mul_b = mul_a;
        acc_en = 1'b1;
        state_next = ST_ECMP;
      end
      ST_ECMP: state_next = ST_FIN;
      ST_X2: begin
        mul_a = MUL_W'(head.ay); mul_b = MUL_W'(head.vx);
        acc_en = 1'b1; acc_neg = 1'b1;
        state_next = ST_W0;
      end
      // Wide compare: cross^2 - r2 * len2 in 18-bit limbs
      ST_W0: begin
        mul_a = limb(PIECE_W'(r2[RSQ_W-1:PIECE_W])); mul_b = limb(len2[LEN_W-1:PIECE_W]);
        mul_sh = SH_HI; acc_en = 1'b1; acc_clr = 1'b1; acc_neg = 1'b1;
        state_next = ST_W1;
      end
      ST_W1: begin
        mul_a = limb(PIECE_W'(r2[RSQ_W-1:PIECE_W])); mul_b = limb(len2[PIECE_W-1:0]);
        mul_sh = SH_MID; acc_en = 1'b1; acc_neg = 1'b1;
        state_next = ST_W2;
      end
      ST_W2: begin
        mul_a = limb(r2[PIECE_W-1:0]); mul_b = limb(len2[LEN_W-1:PIECE_W]);
        mul_sh = SH_MID; acc_en = 1'b1; acc_neg = 1'b1;
        state_next = ST_W3;
      end
      ST_W3: begin
        mul_a = limb(r2[PIECE_W-1:0]); mul_b = limb(len2[PIECE_W-1:0]);
        acc_en = 1'b1; acc_neg = 1'b1;
        state_next = ST_W4;
      end
      ST_W4: begin
        mul_a = limb(cr[LEN_W-1:PIECE_W]); mul_b = limb(cr[LEN_W-1:PIECE_W]);
        mul_sh = SH_HI; acc_en = 1'b1;
        state_next = ST_W5;
      end
      ST_W5: begin
        mul_a = limb(cr[LEN_W-1:PIECE_W]); mul_b = limb(cr[PIECE_W-1:0]);
        mul_sh = SH_MID2; acc_en = 1'b1;
        state_next = ST_W6;
      end
      ST_W6: begin
        mul_a = limb(cr[PIECE_W-1:0]); mul_b = limb(cr[PIECE_W-1:0]);
        acc_en = 1'b1;
        state_next = ST_WCMP;
      end
      ST_WCMP: state_next = ST_FIN;
      ST_FIN: begin
        if (!result_valid || result_ready) begin
          pop        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc <= acc_next;
    end
    if (state == ST_IDLE) begin
      hc <= 1'b0;
      hl <= 1'b0;
    end
    if (state == ST_LAA) begin
      hc <= acc_le0;
    end
    if (state == ST_DAV) begin
      len2 <= acc[LEN_W-1:0];
    end
    if (state == ST_RSQ) begin
      dot <= acc[shht_pkg::DOT_W-1:0];
    end
    if (state == ST_BR) begin
      r2    <= acc[RSQ_W-1:0];
      sel_w <= !dot_le0;
    end
    if (state == ST_ECMP) begin
      hl <= (acc <= $signed(ACC_W'(r2)));
    end
    if (state == ST_W0) begin
      cr <= acc_abs[LEN_W-1:0];
    end
    if (state == ST_WCMP) begin
      hl <= acc_le0;
    end
  end

  // Hover flag update and event
  always_comb begin
    if (head.kind == shht_pkg::KIND_BLOCKED) begin
      hover_next  = 1'b0;
      centre_next = centre_hover_flag;
      event_next  = hover_flag ? shht_pkg::EV_STOP : shht_pkg::EV_NONE;
    end else begin
      hover_next  = hc || hl;
      centre_next = hc;
      if (hover_next != hover_flag || hc != centre_hover_flag) begin
        event_next = hover_next ? shht_pkg::EV_START : shht_pkg::EV_STOP;
      end else begin
        event_next = shht_pkg::EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hover_flag        <= 1'b0;
      centre_hover_flag <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      if (pop) begin
        hover_flag        <= hover_next;
        centre_hover_flag <= centre_next;
        result_valid      <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pop) begin
      result.hover        <= hover_next;
      result.centre_hover <= centre_next;
      result.hover_event  <= event_next;
    end
  end

endmodule

// ===== hdl/segment_hover_hit_test.sv =====
// Top level of the segment hover hit test: front end, work queue and back end.

// Each pointer move beat is tested against the connector drawn between the centres of its two
// boxes (Q12.4 coordinates) and answered by one result beat with the hover flag, the
// centre-hover flag and any hover start or stop event. The front end classifies a move and
// queues it in the same cycle it is accepted; the queue holds QUEUE_DEPTH moves, so until it
// is full the input keeps taking beats while the back end works and while a result waits.
// The back end has a single 20x20 multiplier stepped by a sequencer, at most one product per
// cycle. Blocked moves and those missing ends go straight to the result; others end at a
// centre hit or zero-length segment or test the end point or perpendicular foot distance,
// the foot by an exact compare of 18-bit limbs. Moves are handled in order, one at a time in
// the back end. line_width and centre_size are written through cfg_we/cfg_index/cfg_data
// only while no move is in flight, a rule on the user, as the block does not enforce it.
module segment_hover_hit_test #(
  parameter int QUEUE_DEPTH = shht_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [shht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shht_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  shht_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output shht_pkg::result_t              result
);

  shht_pkg::queue_stat_t q_stat;
  shht_pkg::work_t       work_in;
  shht_pkg::work_t       work_head;
  logic                  push;
  logic                  pop;

  shht_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .stat       (q_stat),
    .push       (push),
    .work       (work_in)
  );

  shht_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (work_in),
    .pop   (pop),
    .rdata (work_head),
    .stat  (q_stat)
  );

  shht_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (work_head),
    .stat         (q_stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Back end only retires a move that is really queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("retire from empty work queue");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!result_valid || result_ready))
    else $error("result register overwritten");

  // Event code agrees with the reported hover flag
  a_start_hover: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hover_event == shht_pkg::EV_START) |-> result.hover)
    else $error("hover start without hover");

  a_stop_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hover_event == shht_pkg::EV_STOP) |-> !result.hover)
    else $error("hover stop with hover set");

endmodule
